FILE: src/spi_master_byte_shifter_unit_defines.svh
// Assertion macros for the SPI master byte shifter.
// Included by modules that check their own state; needs clk and arst_n in scope.
`ifndef SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH
`define SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sms assertion failed");

// Check that cons holds in the cycle after ante holds.
`define SMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sms assertion failed");

`endif

FILE: src/sms_pkg.sv
// Shared types, codes and helpers of the SPI master byte shifter.
// No dependencies; used by the input channel interface, the top level and the bench.
package sms_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] reg_idx_t;
	typedef logic [6:0] presc_t;

	localparam cmd_t CMD_TICK  = 2'd0;
	localparam cmd_t CMD_WRITE = 2'd1;
	localparam cmd_t CMD_READ  = 2'd2;
	localparam cmd_t CMD_CLEAR = 2'd3;

	localparam reg_idx_t REG_ENABLE  = 3'd0;
	localparam reg_idx_t REG_IRQ_EN  = 3'd1;
	localparam reg_idx_t REG_LSB     = 3'd2;
	localparam reg_idx_t REG_CPOL    = 3'd3;
	localparam reg_idx_t REG_CPHA    = 3'd4;
	localparam reg_idx_t REG_RATE    = 3'd5;
	localparam reg_idx_t REG_DOUBLE  = 3'd6;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Half period of the serial clock in ticks, by rate select.
	localparam presc_t HALF_PERIOD [4] = '{7'd2, 7'd8, 7'd32, 7'd64};

	// Bit that leaves first from a byte in the given order.
	function automatic logic first_bit(input logic lsb, input logic [7:0] b);
		return lsb ? b[0] : b[7];
	endfunction

endpackage

FILE: src/sms_in_if.sv
// Input channel of the SPI master byte shifter: valid/ready plus one command beat.
// Depends on sms_pkg for the command type.
interface sms_in_if;
	logic             valid;
	logic             ready;
	sms_pkg::cmd_t    command;
	logic [7:0]       write_byte;
	logic             miso_in;

	modport source (output valid, output command, output write_byte, output miso_in,
		input ready);
	modport sink (input valid, input command, input write_byte, input miso_in,
		output ready);
endinterface

// Result channel of the SPI master byte shifter: valid/ready plus one status beat.
interface sms_out_if;
	logic       valid;
	logic       ready;
	logic       sclk_out;
	logic       mosi_out;
	logic       done_flag;
	logic [7:0] read_byte;
	logic       busy_res;
	logic       irq;

	modport source (output valid, output sclk_out, output mosi_out, output done_flag,
		output read_byte, output busy_res, output irq, input ready);
	modport sink (input valid, input sclk_out, input mosi_out, input done_flag,
		input read_byte, input busy_res, input irq, output ready);
endinterface

FILE: src/spi_master_byte_shifter_unit.sv
// SPI master byte shifter: APB register file, prescaler, shifter and result register.
// Depends on sms_pkg, sms_in_if/sms_out_if and the assertion macro header.
//
// Usage:
//  - item (sink) takes one command beat: tick, write data, read data or clear flag.
//    A tick advances the prescaler by one while a transfer runs; every half serial
//    period one sclk edge occurs. Write starts a transfer when enabled and idle.
//  - result (source) returns exactly one status beat per command beat: sclk, mosi,
//    completion flag, last received byte, busy and irq as they stand after it.
//  - APB port writes the seven control registers at byte address 4*index; writes
//    complete in the access cycle (pready is tied high), reads return the value.
//  - Latency: a status beat is valid the cycle after its command beat is taken.
//  - Throughput: one command beat per cycle when not stalled; the whole update is
//    one pass of logic between the state registers and the result register.
//  - Serial timing: sclk period is 4/16/64/128 ticks (half with double speed),
//    set by the 7-bit prescaler.
//  - Stall: while the result register holds an untaken beat and result.ready is
//    low, item.ready drops; the beat holds until taken, nothing is lost.
//  - Reset: arst_n clears all but the result data; engine idles, sclk low, no flag.
`include "spi_master_byte_shifter_unit_defines.svh"

module spi_master_byte_shifter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	sms_in_if.sink                       item,
	sms_out_if.source                    result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sms_pkg::ADDR_W-1:0]   paddr,
	input  logic [sms_pkg::DATA_W-1:0]   pwdata,
	output logic [sms_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import sms_pkg::*;

	// Control registers
	logic       en_q, irq_en_q, lsb_q, cpol_q, cpha_q, dbl_q;
	logic [1:0] rate_q;

	// Engine state
	logic [7:0] sr_q, rx_q;
	logic [3:0] bc_q;
	presc_t     ps_q;
	logic       cl_q, flag_q, act_q, mosi_q, smp_q;

	// Next state after the command beat, then after the register write
	logic [7:0] sr_n, rx_n;
	logic [3:0] bc_n, bc_inc;
	presc_t     ps_n, half;
	logic       cl_n, flag_n, act_n, mosi_n, smp_n;
	logic [3:0] bc_f;
	presc_t     ps_f;
	logic       cl_f, act_f;

	logic [7:0] ps_inc;
	logic [7:0] shifted;
	logic       edge_bit, leading;
	logic       accept, cfg_wr, cpol_new;
	reg_idx_t   idx;

	// Result register
	logic       out_valid_q;
	logic       sclk_q, mosi_o_q, done_q, busy_q, irq_q;
	logic [7:0] rbyte_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// Take a new beat whenever the result slot is free or drains this cycle.
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// APB read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE: prdata[0]   = en_q;
			REG_IRQ_EN: prdata[0]   = irq_en_q;
			REG_LSB:    prdata[0]   = lsb_q;
			REG_CPOL:   prdata[0]   = cpol_q;
			REG_CPHA:   prdata[0]   = cpha_q;
			REG_RATE:   prdata[1:0] = rate_q;
			REG_DOUBLE: prdata[0]   = dbl_q;
			default:    prdata      = '0;
		endcase
	end

	// One command beat: prescaler step, clock edge, shift, load or flag clear.
	always_comb begin
		sr_n   = sr_q;
		rx_n   = rx_q;
		bc_n   = bc_q;
		ps_n   = ps_q;
		cl_n   = cl_q;
		flag_n = flag_q;
		act_n  = act_q;
		mosi_n = mosi_q;
		smp_n  = smp_q;

		half     = HALF_PERIOD[rate_q] >> dbl_q;
		ps_inc   = {1'b0, ps_q} + 8'd1;
		leading  = (cl_q == cpol_q);
		// Phase 1 samples on the very edge that shifts; phase 0 uses the held sample.
		edge_bit = cpha_q ? item.miso_in : smp_q;
		shifted  = lsb_q ? {edge_bit, sr_q[7:1]} : {sr_q[6:0], edge_bit};
		bc_inc   = bc_q + 4'd1;

		if (accept) begin
			case (item.command)
				CMD_TICK: begin
					if (act_q && en_q) begin
						if (ps_inc >= {1'b0, half}) begin
							ps_n = '0;
							cl_n = ~cl_q;
							if (leading) begin
								if (cpha_q) mosi_n = first_bit(lsb_q, sr_q);
								else        smp_n  = item.miso_in;
							end else begin
								if (cpha_q) smp_n = item.miso_in;
								sr_n = shifted;
								bc_n = bc_inc;
								if (bc_inc >= BITS_PER_BYTE) begin
									// Eighth bit in: latch, flag and drop back to idle.
									rx_n   = shifted;
									flag_n = 1'b1;
									act_n  = 1'b0;
									bc_n   = '0;
									ps_n   = '0;
									cl_n   = cpol_q;
								end else if (!cpha_q) begin
									mosi_n = first_bit(lsb_q, shifted);
								end
							end
						end else begin
							ps_n = ps_inc[6:0];
						end
					end
				end
				CMD_WRITE: begin
					if (en_q && !act_q) begin
						sr_n  = item.write_byte;
						bc_n  = '0;
						ps_n  = '0;
						cl_n  = cpol_q;
						act_n = 1'b1;
						if (!cpha_q) mosi_n = first_bit(lsb_q, item.write_byte);
					end
				end
				CMD_READ: begin
				end
				default: flag_n = 1'b0;
			endcase
		end

		// Register write on top: disabling aborts, idle clock follows polarity.
		bc_f     = bc_n;
		ps_f     = ps_n;
		act_f    = act_n;
		cl_f     = cl_n;
		cpol_new = (cfg_wr && idx == REG_CPOL) ? pwdata[0] : cpol_q;
		if (cfg_wr && idx == REG_ENABLE && !pwdata[0]) begin
			act_f = 1'b0;
			bc_f  = '0;
			ps_f  = '0;
		end
		if (cfg_wr && !act_f) cl_f = cpol_new;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			irq_en_q <= 1'b0;
			lsb_q    <= 1'b0;
			cpol_q   <= 1'b0;
			cpha_q   <= 1'b0;
			rate_q   <= '0;
			dbl_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (idx)
				REG_ENABLE: en_q     <= pwdata[0];
				REG_IRQ_EN: irq_en_q <= pwdata[0];
				REG_LSB:    lsb_q    <= pwdata[0];
				REG_CPOL:   cpol_q   <= pwdata[0];
				REG_CPHA:   cpha_q   <= pwdata[0];
				REG_RATE:   rate_q   <= pwdata[1:0];
				REG_DOUBLE: dbl_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q   <= '0;
			rx_q   <= '0;
			bc_q   <= '0;
			ps_q   <= '0;
			cl_q   <= 1'b0;
			flag_q <= 1'b0;
			act_q  <= 1'b0;
			mosi_q <= 1'b0;
			smp_q  <= 1'b0;
		end else begin
			sr_q   <= sr_n;
			rx_q   <= rx_n;
			bc_q   <= bc_f;
			ps_q   <= ps_f;
			cl_q   <= cl_f;
			flag_q <= flag_n;
			act_q  <= act_f;
			mosi_q <= mosi_n;
			smp_q  <= smp_n;
		end
	end

	// Result register: load on accept, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sclk_q   <= act_n ? cl_n : cpol_q;
			mosi_o_q <= mosi_n;
			done_q   <= flag_n;
			rbyte_q  <= rx_n;
			busy_q   <= act_n;
			irq_q    <= flag_n & irq_en_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.sclk_out  = sclk_q;
	assign result.mosi_out  = mosi_o_q;
	assign result.done_flag = done_q;
	assign result.read_byte = rbyte_q;
	assign result.busy_res  = busy_q;
	assign result.irq       = irq_q;

	`SMS_ASSERT_NOW(a_idle_counters_clear, !act_q, bc_q == 4'd0 && ps_q == 7'd0)
	`SMS_ASSERT_NOW(a_bit_count_in_byte, act_q, bc_q < BITS_PER_BYTE)
	`SMS_ASSERT_NOW(a_prescaler_below_max, 1'b1, ps_q[6] == 1'b0)
	`SMS_ASSERT_NEXT(a_write_starts,
		accept && item.command == CMD_WRITE && en_q && !act_q && !cfg_wr, act_q)

endmodule

FILE: test/testbench.sv
// Self-checking bench for the SPI master byte shifter: command beats in, status beats out.
// Needs sms_pkg, the sms_in_if/sms_out_if channels and spi_master_byte_shifter_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sms_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASES = 13;
	localparam int unsigned REPORT_MAX = 10;

	// Status beat as the block reports it after one command beat.
	typedef struct packed {
		logic       sclk;
		logic       mosi;
		logic       flag;
		logic [7:0] rx;
		logic       busy;
		logic       irq;
	} spi_status_t;

	// Mirror of the engine plus the queue of status beats still owed by the block.
	class shifter_scoreboard;
		bit en, ie, lsb, cpol, cpha, dbl;
		bit [1:0] rate;
		bit [7:0] shreg, rxreg;
		bit [3:0] bits;
		bit [6:0] presc;
		bit sclk_lvl, flag, busy, mosi_lvl, sampled;
		spi_status_t status_due[$];
		int unsigned errors, checked, bytes_done, aborted;

		function int unsigned half_ticks();
			int unsigned h;
			case (rate)
				2'd0: h = 2;
				2'd1: h = 8;
				2'd2: h = 32;
				default: h = 64;
			endcase
			return dbl ? h >> 1 : h;
		endfunction

		function bit lead_bit();
			return lsb ? shreg[0] : shreg[7];
		endfunction

		// Finish one bit: pull the sampled level in, end the byte after the eighth.
		function void shift_edge();
			if (lsb)
				shreg = {sampled, shreg[7:1]};
			else
				shreg = {shreg[6:0], sampled};
			bits = bits + 4'd1;
			if (bits >= 4'd8) begin
				rxreg = shreg;
				flag = 1'b1;
				busy = 1'b0;
				bits = '0;
				presc = '0;
				sclk_lvl = cpol;
				bytes_done++;
			end else if (!cpha) begin
				mosi_lvl = lead_bit();
			end
		endfunction

		function void clock_edge(bit miso);
			bit leading;
			leading = (sclk_lvl == cpol);
			sclk_lvl = ~sclk_lvl;
			if (!cpha) begin
				if (leading)
					sampled = miso;
				else
					shift_edge();
			end else if (leading) begin
				mosi_lvl = lead_bit();
			end else begin
				sampled = miso;
				shift_edge();
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_ENABLE: begin
					en = v[0];
					if (!en) begin
						if (busy)
							aborted++;
						busy = 1'b0;
						bits = '0;
						presc = '0;
					end
				end
				REG_IRQ_EN: ie = v[0];
				REG_LSB:    lsb = v[0];
				REG_CPOL:   cpol = v[0];
				REG_CPHA:   cpha = v[0];
				REG_RATE:   rate = v[1:0];
				REG_DOUBLE: dbl = v[0];
				default: ;
			endcase
			if (!busy)
				sclk_lvl = cpol;
		endfunction

		// True for a tick or write that leaves the engine exactly as it was.
		function bit ignored(cmd_t c);
			return (c == CMD_TICK && !(busy && en)) || (c == CMD_WRITE && !(en && !busy));
		endfunction

		// Advance the mirror by one accepted command beat and queue its status.
		function void note_command(cmd_t c, bit [7:0] wb, bit miso);
			spi_status_t s;
			case (c)
				CMD_TICK: begin
					if (busy && en) begin
						if (32'(presc) + 1 >= half_ticks()) begin
							presc = '0;
							clock_edge(miso);
						end else begin
							presc = presc + 7'd1;
						end
					end
				end
				CMD_WRITE: begin
					if (en && !busy) begin
						shreg = wb;
						bits = '0;
						presc = '0;
						sclk_lvl = cpol;
						busy = 1'b1;
						if (!cpha)
							mosi_lvl = lead_bit();
					end
				end
				CMD_CLEAR: flag = 1'b0;
				default: ;
			endcase
			s.sclk = busy ? sclk_lvl : cpol;
			s.mosi = mosi_lvl;
			s.flag = flag;
			s.rx = rxreg;
			s.busy = busy;
			s.irq = flag & ie;
			status_due.push_back(s);
		endfunction

		function void check_status(spi_status_t got);
			spi_status_t want;
			checked++;
			if (status_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("status beat %0d arrived with nothing outstanding", checked);
				return;
			end
			want = status_due.pop_front();
			if (got.sclk !== want.sclk || got.mosi !== want.mosi || got.flag !== want.flag ||
					got.rx !== want.rx || got.busy !== want.busy || got.irq !== want.irq) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("beat %0d: want sclk,mosi,flag=%b%b%b rx=%h busy,irq=%b%b; got %b%b%b %h %b%b",
						checked, want.sclk, want.mosi, want.flag, want.rx, want.busy, want.irq,
						got.sclk, got.mosi, got.flag, got.rx, got.busy, got.irq);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	sms_in_if  cmd_ch ();
	sms_out_if status_ch ();

	shifter_scoreboard sb;
	int unsigned send_idle_pct, recv_idle_pct;
	int unsigned cycles;
	int unsigned beats_sent;

	spi_master_byte_shifter_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (cmd_ch),
		.result  (status_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 8 ns period: high half, then low half.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a correct run finishes well inside this many cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[spi_master_byte_shifter_unit] ERROR");
			$finish;
		end
	end

	// Status side: check every taken beat against the mirror, then pick the
	// next ready level. Values seen here are the ones present at the edge.
	always @(posedge clk) begin
		if (arst_n && status_ch.valid && status_ch.ready)
			sb.check_status('{status_ch.sclk_out, status_ch.mosi_out, status_ch.done_flag,
				status_ch.read_byte, status_ch.busy_res, status_ch.irq});
		status_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one command beat, with random idle cycles in front, and hold it
	// until the block takes it. Valid stays high on return so back-to-back
	// beats need no extra cycle.
	task automatic put_command(cmd_t c, logic [7:0] wb, logic miso);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.write_byte <= wb;
		cmd_ch.miso_in <= miso;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		sb.note_command(c, wb, miso);
		beats_sent++;
	endtask

	// Drop valid and hold off until every owed status beat has come back.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.status_due.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, register lands when pready is seen.
	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Program every control register; the engine must have nothing owed.
	task automatic set_config(bit en, bit ie, bit lsb, bit cpol, bit cpha, bit [1:0] rate,
			bit dbl);
		drain();
		// idle before touching registers
		repeat (2) @(posedge clk);
		reg_write(REG_ENABLE, 32'(en));
		reg_write(REG_IRQ_EN, 32'(ie));
		reg_write(REG_LSB, 32'(lsb));
		reg_write(REG_CPOL, 32'(cpol));
		reg_write(REG_CPHA, 32'(cpha));
		reg_write(REG_RATE, 32'(rate));
		reg_write(REG_DOUBLE, 32'(dbl));
	endtask

	// Hand-picked beats: reset state, ignored writes, one full fast byte.
	task automatic directed_part();
		// disabled after reset: a write goes nowhere, flag and byte stay clear
		put_command(CMD_READ, 8'h00, 1'b0);
		put_command(CMD_TICK, 8'hFF, 1'b1);
		put_command(CMD_WRITE, 8'hA5, 1'b1);
		put_command(CMD_CLEAR, 8'h00, 1'b0);
		// fastest clock (one tick per edge), irq on, MSB first, mode 0
		set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1);
		put_command(CMD_WRITE, 8'hFF, 1'b0);
		// second write while shifting must be dropped
		put_command(CMD_WRITE, 8'h00, 1'b1);
		for (int k = 0; k < 16; k++)
			put_command(CMD_TICK, 8'h5A, k[1]);
		put_command(CMD_READ, 8'h00, 1'b1);
		put_command(CMD_CLEAR, 8'hFF, 1'b0);
	endtask

	// One random phase: pick the settings, then mostly well-formed traffic
	// (a write, then ticks until the byte is out) with reads and clears mixed in.
	task automatic run_phase(int unsigned ph);
		bit en, ie, lsb, cpol, cpha, dbl;
		bit [1:0] rate;
		int unsigned quota, counted, r, mode;
		cmd_t c;
		mode = ph * 3 / PHASES;
		case (ph)
			// all-zero options except enable: rate select 0 without double speed
			0: {en, ie, lsb, cpol, cpha, rate, dbl} = 8'b1_0_0_0_0_00_0;
			// every one-bit option set, fastest clock
			1: {en, ie, lsb, cpol, cpha, rate, dbl} = 8'b1_1_1_1_1_00_1;
			// slowest clock: only a few edges fit, the byte runs into the next phase
			2: {en, ie, lsb, cpol, cpha, rate, dbl} = 8'b1_1_1_1_1_11_0;
			default: begin
				{ie, lsb, cpol, cpha, dbl} = 5'($urandom);
				r = $urandom_range(99);
				rate = (r < 70) ? 2'd0 : (r < 94) ? 2'd1 : 2'd2;
				en = ($urandom_range(9) != 0);
				// fast clock right after the slow one: prescaler already past the half period
				if (ph == 3) begin
					en = 1'b1;
					rate = 2'd0;
					dbl = 1'b1;
				end
				// disable with a byte in flight: abort
				if (ph == 4)
					en = 1'b0;
			end
		endcase
		set_config(en, ie, lsb, cpol, cpha, rate, dbl);
		send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 71 : 0;
		recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 37 : 0;
		quota = (ph == 2) ? 150 : (!en) ? 30 : 95;
		counted = 0;
		while (counted < quota) begin
			r = $urandom_range(99);
			if (sb.busy && sb.en)
				c = (r < 85) ? CMD_TICK : (r < 89) ? CMD_WRITE : (r < 94) ? CMD_READ : CMD_CLEAR;
			else
				c = (r < 55) ? CMD_WRITE : (r < 65) ? CMD_TICK : (r < 80) ? CMD_READ : CMD_CLEAR;
			if (!sb.ignored(c))
				counted++;
			put_command(c, 8'($urandom), 1'($urandom));
			// now and then hold the sender until the block has caught up
			if ($urandom_range(99) == 0)
				drain();
		end
		// leave a byte in flight so the next settings land mid-transfer
		put_command(CMD_WRITE, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		sb = new;
		beats_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.write_byte = '0;
		cmd_ch.miso_in = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();
		for (int unsigned ph = 0; ph < PHASES; ph++)
			run_phase(ph);

		drain();
		// give any stray status beat time to arrive
		repeat (8) @(posedge clk);
		if (sb.status_due.size() != 0) begin
			sb.errors++;
			$display("%0d status beats never arrived", sb.status_due.size());
		end

		$display("sent %0d command beats, checked %0d status beats, %0d bad",
			beats_sent, sb.checked, sb.errors);
		$display("%0d bytes shifted, %0d transfers aborted, %0d register settings",
			sb.bytes_done, sb.aborted, PHASES + 1);
		if (sb.errors == 0)
			$display("[spi_master_byte_shifter_unit] OK");
		else
			$display("[spi_master_byte_shifter_unit] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/sms_pkg.sv
src/sms_in_if.sv
src/spi_master_byte_shifter_unit.sv
test/testbench.sv
